@@ rtl/kts_pkg.sv @@
// Shared constants, types and classification functions for the keyword token scanner.
package kts_pkg;

  // Field widths and default sizes
  localparam int CH_W             = 8;
  localparam int KIND_W           = 5;
  localparam int OFFSET_WIDTH_DEF = 24;
  localparam int LINE_WIDTH_DEF   = 16;
  localparam int PFX_DEPTH        = 5;
  localparam int Q_DEPTH          = 4;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd10;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd11;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd12;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd13;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd14;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd15;
  localparam logic [KIND_W-1:0] KIND_DOT    = 5'd16;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd17;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd18;
  localparam logic [KIND_W-1:0] KIND_EOF    = 5'd19;

  // Special bytes
  localparam logic [CH_W-1:0] CH_EOS    = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CH_W-1:0] CH_SP     = 8'h20;
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;

  // Keyword table, kind = position + 1; short words padded with zero bytes
  localparam int KW_NUM = 9;
  localparam logic [0:KW_NUM-1][0:PFX_DEPTH-1][CH_W-1:0] KW_TEXT = {
    "async", "await", "class", {"enum", 8'h00}, {"fn", 24'h0},
    "getlf", {"if", 24'h0}, {"let", 16'h0}, {"use", 16'h0}
  };
  localparam logic [0:KW_NUM-1][2:0] KW_LEN = {
    3'd5, 3'd5, 3'd5, 3'd4, 3'd2, 3'd5, 3'd2, 3'd3, 3'd3
  };

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } kts_q_stat_t;

  function automatic logic is_letter(input logic [CH_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [CH_W-1:0] c);
    return c == CH_SP || c == CH_CR || c == CH_TAB || c == CH_LF;
  endfunction

  // Single-byte token kind; anything not punctuation is an error token
  function automatic logic [KIND_W-1:0] punct_kind(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] kind;
    case (c)
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_LBRACE: kind = KIND_LBRACE;
      CH_RBRACE: kind = KIND_RBRACE;
      CH_SEMI:   kind = KIND_SEMI;
      CH_EQ:     kind = KIND_ASSIGN;
      CH_DOT:    kind = KIND_DOT;
      CH_PLUS:   kind = KIND_PLUS;
      default:   kind = KIND_ERROR;
    endcase
    return kind;
  endfunction

  // Keyword match on the stored prefix; len is zero when too long to match
  function automatic logic [KIND_W-1:0] kw_kind(
    input logic [0:PFX_DEPTH-1][CH_W-1:0] pfx,
    input logic [2:0]                     len
  );
    logic [KIND_W-1:0] kind;
    logic              hit;
    kind = KIND_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      hit = (len == KW_LEN[k]);
      for (int i = 0; i < PFX_DEPTH; i++) begin
        if (i < int'(KW_LEN[k]) && pfx[i] != KW_TEXT[k][i]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        kind = KIND_W'(k + 1);
      end
    end
    return kind;
  endfunction

endpackage

@@ rtl/kts_if.sv @@
// Channel interfaces: source byte requests in, token requests out.
interface kts_byte_if import kts_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface kts_tok_if import kts_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       token_kind;
  logic [OFFSET_WIDTH-1:0] token_start;
  logic [OFFSET_WIDTH-1:0] token_length;
  logic [LINE_WIDTH-1:0]   token_line;
  logic                    last_of_run;

  modport source (output valid, output token_kind, output token_start, output token_length,
                  output token_line, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_start, input token_length,
                  input token_line, input last_of_run, output ready);
endinterface

@@ rtl/kts_front.sv @@
// Front end: accepts source bytes, tracks position and identifiers, builds token pairs.
module kts_front import kts_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
  localparam int TOK_W       = KIND_W + 2 * OFFSET_WIDTH + LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  kts_byte_if.sink          in_if,
  input  kts_q_stat_t       q_stat,
  output logic              push_o,
  output logic [2*TOK_W:0]  entry_o
);

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = '1;

  logic [OFFSET_WIDTH-1:0] off_r, off_nxt;
  logic [OFFSET_WIDTH-1:0] beg_r, beg_nxt;
  logic [OFFSET_WIDTH-1:0] len_r, len_nxt;
  logic [LINE_WIDTH-1:0]   line_r, line_nxt;
  logic                    act_r, act_nxt;
  logic [CH_W-1:0]         pfx_r [PFX_DEPTH];

  logic                    accept;
  logic [CH_W-1:0]         c;
  logic                    grow;
  logic                    start_id;
  logic [OFFSET_WIDTH-1:0] off_inc, len_inc;
  logic [LINE_WIDTH-1:0]   line_inc;
  logic [2:0]              len3;
  logic                    ch_tok_v;
  logic [KIND_W-1:0]       ch_kind;
  logic [OFFSET_WIDTH-1:0] ch_len;
  logic [TOK_W-1:0]        id_tok, ch_tok;

  assign in_if.ready = !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign c           = in_if.ch;

  // saturating increments
  assign off_inc  = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;
  assign len_inc  = (len_r == OFF_MAX) ? len_r : len_r + 1'b1;
  assign line_inc = (line_r == LINE_MAX) ? line_r : line_r + 1'b1;

  assign grow     = act_r && (is_letter(c) || is_digit(c));
  assign start_id = !act_r && is_letter(c);

  // pending identifier token, classified against the keyword table
  assign len3   = (len_r <= OFFSET_WIDTH'(PFX_DEPTH)) ? len_r[2:0] : 3'd0;
  assign id_tok = {kw_kind({pfx_r[0], pfx_r[1], pfx_r[2], pfx_r[3], pfx_r[4]}, len3),
                   beg_r, len_r, line_r};
  assign ch_tok = {ch_kind, off_r, ch_len, line_r};

  // next state and the token of the current byte
  always_comb begin
    off_nxt  = off_r;
    beg_nxt  = beg_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    act_nxt  = act_r;
    ch_tok_v = 1'b0;
    ch_kind  = KIND_ERROR;
    ch_len   = OFFSET_WIDTH'(1);
    if (grow) begin
      len_nxt = len_inc;
      off_nxt = off_inc;
    end else begin
      act_nxt = 1'b0;
      priority if (c == CH_EOS) begin
        ch_tok_v = 1'b1;
        ch_kind  = KIND_EOF;
        ch_len   = '0;
        off_nxt  = '0;
        line_nxt = LINE_WIDTH'(1);
      end else if (is_space(c)) begin
        if (c == CH_LF) begin
          line_nxt = line_inc;
        end
        off_nxt = off_inc;
      end else if (is_letter(c)) begin
        act_nxt = 1'b1;
        beg_nxt = off_r;
        len_nxt = OFFSET_WIDTH'(1);
        off_nxt = off_inc;
      end else begin
        ch_tok_v = 1'b1;
        ch_kind  = punct_kind(c);
        off_nxt  = off_inc;
      end
    end
  end

  // queue entry: flag for two tokens, then first and second token
  assign push_o  = accept && !grow && (act_r || ch_tok_v);
  assign entry_o = {act_r && ch_tok_v, act_r ? id_tok : ch_tok, ch_tok};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      beg_r  <= '0;
      len_r  <= '0;
      line_r <= LINE_WIDTH'(1);
      act_r  <= 1'b0;
    end else if (accept) begin
      off_r  <= off_nxt;
      beg_r  <= beg_nxt;
      len_r  <= len_nxt;
      line_r <= line_nxt;
      act_r  <= act_nxt;
    end
  end

  // first five bytes of the identifier
  always_ff @(posedge clk) begin
    if (accept) begin
      if (grow && len_r < OFFSET_WIDTH'(PFX_DEPTH)) begin
        pfx_r[len_r[2:0]] <= c;
      end else if (start_id) begin
        pfx_r[0] <= c;
      end
    end
  end

  a_act_len: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> len_r != '0)
    else $error("pending identifier with zero length");

  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> line_r != '0)
    else $error("line counter reached zero");

endmodule

@@ rtl/kts_fifo.sv @@
// Small register queue holding token pairs between front and back end.
module kts_fifo import kts_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output kts_q_stat_t      stat_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign stat_o.full  = (count_r == CNT_W'(DEPTH));
  assign stat_o.empty = (count_r == '0);
  assign data_o       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // pointers wrap at the depth, count tracks occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + 1'b1;
      end else if (pop_i && !push_i) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> !stat_o.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> !stat_o.empty)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ rtl/kts_back.sv @@
// Back end: splits queued token pairs and drives the registered token channel.
module kts_back import kts_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF,
  localparam int TOK_W       = KIND_W + 2 * OFFSET_WIDTH + LINE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [2*TOK_W:0]  entry_i,
  input  kts_q_stat_t       q_stat,
  output logic              pop_o,
  kts_tok_if.source         out_if
);

  logic                    val_r;
  logic                    half_r;
  logic [KIND_W-1:0]       kind_r;
  logic [OFFSET_WIDTH-1:0] start_r, len_r;
  logic [LINE_WIDTH-1:0]   line_r;
  logic                    last_r;

  logic                    two;
  logic                    load;
  logic                    final_half;
  logic [TOK_W-1:0]        sel_tok;

  assign two        = entry_i[2*TOK_W];
  assign sel_tok    = half_r ? entry_i[TOK_W-1:0] : entry_i[2*TOK_W-1:TOK_W];
  assign final_half = !two || half_r;

  // load the output register when the queue holds an entry and the register is free or being drained
  assign load  = !q_stat.empty && (!val_r || out_if.ready);
  assign pop_o = load && final_half;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r  <= 1'b0;
      half_r <= 1'b0;
    end else begin
      if (load) begin
        val_r  <= 1'b1;
        half_r <= !final_half;
      end else if (out_if.ready) begin
        val_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      {kind_r, start_r, len_r, line_r} <= sel_tok;
      last_r                           <= final_half;
    end
  end

  assign out_if.valid        = val_r;
  assign out_if.token_kind   = kind_r;
  assign out_if.token_start  = start_r;
  assign out_if.token_length = len_r;
  assign out_if.token_line   = line_r;
  assign out_if.last_of_run  = last_r;

  a_half_held: assert property (@(posedge clk) disable iff (!rst_n)
    half_r |-> !q_stat.empty)
    else $error("second token pending with empty queue");

endmodule

@@ rtl/keyword_token_scanner_core.sv @@
// Keyword token scanner top level: front end, pair queue and output stage.
// Takes one source byte per request and returns tokens (kind, start offset,
// length, line, last_of_run). A byte is accepted every cycle while the
// four-entry pair queue has room; the input side never waits on the output
// side directly. Most bytes give zero or one token, but a byte that ends a
// pending identifier and also forms a token of its own gives two, and the
// output register delivers those one after the other, so sustained throughput is
// one byte per cycle while the output takes one token per cycle and no more
// than one byte in two yields a pair. A token is registered into the queue and
// then into the output register. Byte 0 ends the source: it flushes any
// identifier, emits eof and returns the offset to 0 and the line to 1. Offsets,
// lengths and lines saturate at their all-ones values.
module keyword_token_scanner_core import kts_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  kts_byte_if.sink  in_if,
  kts_tok_if.source out_if
);

  localparam int TOK_W = KIND_W + 2 * OFFSET_WIDTH + LINE_WIDTH;
  localparam int ENT_W = 2 * TOK_W + 1;

  logic             push;
  logic             pop;
  logic [ENT_W-1:0] entry;
  logic [ENT_W-1:0] q_head;
  kts_q_stat_t      q_stat;

  // byte classification and position tracking
  kts_front #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_stat  (q_stat),
    .push_o  (push),
    .entry_o (entry)
  );

  // decoupling queue of token pairs
  kts_fifo #(
    .WIDTH (ENT_W),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .data_i (entry),
    .pop_i  (pop),
    .data_o (q_head),
    .stat_o (q_stat)
  );

  // token delivery
  kts_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH),
    .LINE_WIDTH   (LINE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .entry_i (q_head),
    .q_stat  (q_stat),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

@@ tb/kts_token_checker.sv @@
// Token checker for the keyword token scanner: tracks the lexer state and compares every token.
`timescale 1ns / 100ps
module kts_token_checker import kts_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF,
  parameter int LINE_WIDTH   = LINE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [CH_W-1:0]         in_ch,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [KIND_W-1:0]       out_token_kind,
  input  logic [OFFSET_WIDTH-1:0] out_token_start,
  input  logic [OFFSET_WIDTH-1:0] out_token_length,
  input  logic [LINE_WIDTH-1:0]   out_token_line,
  input  logic                    out_last_of_run,
  output int                      fail_count,
  output int                      pending
);

  // Keyword kinds follow the order of the keyword list
  localparam logic [KIND_W-1:0] KIND_ASYNC = 5'd1;
  localparam logic [KIND_W-1:0] KIND_AWAIT = 5'd2;
  localparam logic [KIND_W-1:0] KIND_CLASS = 5'd3;
  localparam logic [KIND_W-1:0] KIND_ENUM  = 5'd4;
  localparam logic [KIND_W-1:0] KIND_FN    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_GETLF = 5'd6;
  localparam logic [KIND_W-1:0] KIND_IF    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_LET   = 5'd8;
  localparam logic [KIND_W-1:0] KIND_USE   = 5'd9;

  localparam logic [OFFSET_WIDTH-1:0] OFF_SAT  = '1;
  localparam logic [LINE_WIDTH-1:0]   LINE_SAT = '1;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [OFFSET_WIDTH-1:0] start;
    logic [OFFSET_WIDTH-1:0] length;
    logic [LINE_WIDTH-1:0]   line;
    logic                    run_last;
  } token_t;

  // Mirrored lexer state; word_head keeps the first five bytes, first byte at the top
  logic [OFFSET_WIDTH-1:0] next_offset;
  logic [LINE_WIDTH-1:0]   cur_line;
  logic                    word_open;
  logic [OFFSET_WIDTH-1:0] word_start;
  logic [OFFSET_WIDTH-1:0] word_len;
  logic [39:0]             word_head;

  token_t expected_tokens[$];
  int     fails = 0;

  function automatic logic alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [OFFSET_WIDTH-1:0] bump_off(input logic [OFFSET_WIDTH-1:0] v);
    return (v == OFF_SAT) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_WIDTH-1:0] bump_line(input logic [LINE_WIDTH-1:0] v);
    return (v == LINE_SAT) ? v : v + 1'b1;
  endfunction

  // Only the first len bytes of the head are meaningful; longer words stay identifiers
  function automatic logic [KIND_W-1:0] keyword_kind(input logic [39:0] head,
                                                     input logic [OFFSET_WIDTH-1:0] len);
    logic [KIND_W-1:0] k;
    k = KIND_IDENT;
    case (len)
      5: begin
        case (head)
          "async": k = KIND_ASYNC;
          "await": k = KIND_AWAIT;
          "class": k = KIND_CLASS;
          "getlf": k = KIND_GETLF;
          default: k = KIND_IDENT;
        endcase
      end
      4: begin
        if (head[39:8] == "enum") k = KIND_ENUM;
      end
      3: begin
        if (head[39:16] == "let") k = KIND_LET;
        else if (head[39:16] == "use") k = KIND_USE;
      end
      2: begin
        if (head[39:24] == "fn") k = KIND_FN;
        else if (head[39:24] == "if") k = KIND_IF;
      end
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  // Work out the tokens one accepted byte causes and queue them
  task automatic scan_byte(input logic [7:0] c);
    token_t            toks[2];
    int                n;
    int                idx;
    logic [KIND_W-1:0] pk;
    n = 0;
    if (word_open) begin
      if (alpha(c) || numeral(c)) begin
        if (word_len < 5) begin
          idx = int'(word_len);
          word_head[39 - 8 * idx -: 8] = c;
        end
        word_len    = bump_off(word_len);
        next_offset = bump_off(next_offset);
        return;
      end
      // pending word ends here and goes out first
      toks[n] = '{keyword_kind(word_head, word_len), word_start, word_len, cur_line, 1'b0};
      n++;
      word_open = 1'b0;
    end

    if (c == CH_EOS) begin
      toks[n] = '{KIND_EOF, next_offset, '0, cur_line, 1'b0};
      n++;
      next_offset = '0;
      cur_line    = 1;
    end else if (c == CH_SP || c == CH_CR || c == CH_TAB || c == CH_LF) begin
      if (c == CH_LF) cur_line = bump_line(cur_line);
      next_offset = bump_off(next_offset);
    end else if (alpha(c)) begin
      word_open        = 1'b1;
      word_start       = next_offset;
      word_len         = 1;
      word_head[39:32] = c;
      next_offset      = bump_off(next_offset);
    end else begin
      case (c)
        CH_LPAREN: pk = KIND_LPAREN;
        CH_RPAREN: pk = KIND_RPAREN;
        CH_LBRACE: pk = KIND_LBRACE;
        CH_RBRACE: pk = KIND_RBRACE;
        CH_SEMI:   pk = KIND_SEMI;
        CH_EQ:     pk = KIND_ASSIGN;
        CH_DOT:    pk = KIND_DOT;
        CH_PLUS:   pk = KIND_PLUS;
        default:   pk = KIND_ERROR;
      endcase
      toks[n] = '{pk, next_offset, 1, cur_line, 1'b0};
      n++;
      next_offset = bump_off(next_offset);
    end

    for (int i = 0; i < n; i++) begin
      toks[i].run_last = (i == n - 1);
      expected_tokens.push_back(toks[i]);
    end
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  // Results are checked before the byte of the same edge is predicted; latency keeps them apart
  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      next_offset = '0;
      cur_line    = 1;
      word_open   = 1'b0;
      word_start  = '0;
      word_len    = '0;
      word_head   = '0;
      expected_tokens.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d start %0d length %0d line %0d",
                 out_token_kind, out_token_start, out_token_length, out_token_line);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.kind, out_token_kind);
          check_field("token_start", want.start, out_token_start);
          check_field("token_length", want.length, out_token_length);
          check_field("token_line", want.line, out_token_line);
          check_field("last_of_run", want.run_last, out_last_of_run);
        end
      end
      if (in_valid && in_ready) scan_byte(in_ch);
    end
    pending    <= expected_tokens.size();
    fail_count <= fails;
  end

endmodule

@@ tb/tb_keyword_token_scanner_core.sv @@
// Testbench top for the keyword token scanner: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module tb_keyword_token_scanner_core;
  import kts_pkg::*;

  localparam int CYCLE_LIMIT      = 100_000;
  localparam int RANDOM_PER_PHASE = 270;
  localparam int LF_BURST         = 24;

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   phase_bytes;

  string      keyword_words[9] = '{"async", "await", "class", "enum", "fn",
                                   "getlf", "if", "let", "use"};
  logic [7:0] punct_bytes[8]   = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                   CH_SEMI, CH_EQ, CH_DOT, CH_PLUS};
  logic [7:0] space_bytes[4]   = '{CH_SP, CH_TAB, CH_CR, CH_LF};

  kts_byte_if in_if ();
  kts_tok_if  out_if ();

  keyword_token_scanner_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  kts_token_checker u_token_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_ch            (in_if.ch),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_token_kind   (out_if.token_kind),
    .out_token_start  (out_if.token_start),
    .out_token_length (out_if.token_length),
    .out_token_line   (out_if.token_line),
    .out_last_of_run  (out_if.last_of_run),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Token sink with random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL keyword_token_scanner_core");
      $finish;
    end
  end

  // One byte request, with random idle cycles in front of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.ch    <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    phase_bytes++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender off until every predicted token has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    int n;
    n = $urandom_range(0, 51);
    return (n < 26) ? 8'("a" + n) : 8'("A" + n - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int n;
    n = $urandom_range(0, 61);
    return (n < 10) ? 8'("0" + n) : ((n < 36) ? 8'("a" + n - 10) : 8'("A" + n - 36));
  endfunction

  // One lexical unit of random source: mostly well-formed, some near misses and noise
  task automatic send_token();
    int    pick;
    string w;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_text(keyword_words[$urandom_range(0, 8)]);
    end else if (pick < 35) begin
      w = keyword_words[$urandom_range(0, 8)];
      case ($urandom_range(0, 2))
        0: begin
          send_text(w);
          send_byte(rand_alnum());
        end
        1: send_text(w.substr(0, w.len() - 2));
        default: begin
          // upper-case first letter must not match
          send_byte(w[0] - 8'h20);
          send_text(w.substr(1, w.len() - 1));
        end
      endcase
    end else if (pick < 50) begin
      send_byte(rand_letter());
      repeat ($urandom_range(0, 7)) send_byte(rand_alnum());
    end else if (pick < 72) begin
      send_byte(punct_bytes[$urandom_range(0, 7)]);
    end else if (pick < 87) begin
      send_byte(space_bytes[$urandom_range(0, 3)]);
    end else if (pick < 96) begin
      case ($urandom_range(0, 3))
        0, 1: send_byte(8'("0" + $urandom_range(0, 9)));
        2:    send_byte(8'($urandom_range(128, 255)));
        default: send_byte(8'($urandom_range(1, 255)));
      endcase
    end else if (pick < 98) begin
      send_byte(CH_EOS);
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.ch    <= CH_EOS;
    rst_n       <= 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    phase_bytes = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: keyword, word ended by punctuation, all punctuation, errors, long word, end of source
    send_text("async ");
    send_text("fn(");
    send_text("){};=.+");
    send_byte(8'hFF);
    send_byte("7");
    send_byte(CH_LF);
    send_byte(CH_TAB);
    send_text("Zq9zzy");
    send_byte(CH_EOS);
    send_byte(CH_EOS);
    wait_drained();

    // Random source under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 51; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 9;  stall_pct = 9;  end
      endcase
      phase_bytes = 0;
      while (phase_bytes < RANDOM_PER_PHASE) begin
        send_token();
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      wait_drained();
    end

    // Run of line feeds, then end of source brings the line back to one
    idle_pct  = 0;
    stall_pct = 0;
    repeat (LF_BURST) send_byte(CH_LF);
    send_text("x;");
    send_byte(CH_EOS);
    send_text("if");
    send_byte(CH_EOS);
    wait_drained();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS keyword_token_scanner_core");
    end else begin
      $display("FAIL keyword_token_scanner_core");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kts_pkg.sv
rtl/kts_if.sv
rtl/kts_front.sv
rtl/kts_fifo.sv
rtl/kts_back.sv
rtl/keyword_token_scanner_core.sv
tb/kts_token_checker.sv
tb/tb_keyword_token_scanner_core.sv
